/* design/kpar_pkg.sv */
// ----------------------------------------------------------------------------
// kpar_pkg: shared types and constants for the keypad override/autorepeat block
// Key table, key masks, operation codes and the key-info bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package kpar_pkg;

	localparam int NUM_KEYS  = 13;
	localparam int KEY_W     = 4;
	localparam int WORD_W    = 32;
	localparam int DELAY_W   = 16;
	localparam int OP_W      = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [OP_W-1:0] OP_SCAN     = 3'd0;
	localparam logic [OP_W-1:0] OP_PRESS    = 3'd1;
	localparam logic [OP_W-1:0] OP_RELEASE  = 3'd2;
	localparam logic [OP_W-1:0] OP_REL_ALL  = 3'd3;
	localparam logic [OP_W-1:0] OP_AREP_RST = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY = 2'd1;

	localparam logic [DELAY_W-1:0] FIRST_DELAY_RESET  = 16'd500;
	localparam logic [DELAY_W-1:0] REPEAT_DELAY_RESET = 16'd175;

	localparam logic [WORD_W-1:0] GROUP0_MASK = 32'h0000_0300;
	localparam logic [WORD_W-1:0] GROUP1_MASK = 32'h0000_FF30;
	localparam logic [WORD_W-1:0] ALL_ONES    = 32'hFFFF_FFFF;

	// bit k describes key k+1: 1 = group 1, 0 = group 0
	localparam logic [NUM_KEYS-1:0] KEY_GRP = 13'b1111100011111;

	// entry k holds the bits of key k+1 (all key bits sit in the low half word)
	localparam logic [NUM_KEYS-1:0][15:0] KEY_BITS = {
		16'h0800, 16'h1000, 16'h2000, 16'h0020, 16'h0010, 16'h0100, 16'h0200,
		16'h0300, 16'h8000, 16'h0200, 16'h0100, 16'h0400, 16'h4000
	};

	typedef struct packed {
		logic [KEY_W-1:0]    pressed;
		logic [KEY_W-1:0]    clicked;
		logic [NUM_KEYS-1:0] down;
	} key_info_t;

endpackage

`default_nettype wire

/* design/kpar_keyenc.sv */
// ----------------------------------------------------------------------------
// kpar_keyenc: key table priority encoder
// Finds the first pressed and first newly clicked key in table order.
// ----------------------------------------------------------------------------
`default_nettype none

module kpar_keyenc (
	input  wire logic [kpar_pkg::WORD_W-1:0] cur0,
	input  wire logic [kpar_pkg::WORD_W-1:0] cur1,
	input  wire logic [kpar_pkg::WORD_W-1:0] prev0,
	input  wire logic [kpar_pkg::WORD_W-1:0] prev1,
	output kpar_pkg::key_info_t              info
);

	logic [kpar_pkg::NUM_KEYS-1:0] down;
	logic [kpar_pkg::NUM_KEYS-1:0] click;

	always_comb begin
		for (int k = 0; k < kpar_pkg::NUM_KEYS; k++) begin
			if (kpar_pkg::KEY_GRP[k]) begin
				down[k]  = (cur1[15:0] & kpar_pkg::KEY_BITS[k]) == 16'h0;
				click[k] = down[k] && ((prev1[15:0] & kpar_pkg::KEY_BITS[k]) != 16'h0);
			end else begin
				down[k]  = (cur0[15:0] & kpar_pkg::KEY_BITS[k]) == 16'h0;
				click[k] = down[k] && ((prev0[15:0] & kpar_pkg::KEY_BITS[k]) != 16'h0);
			end
		end
	end

	// walk from the end so the lowest table entry wins
	always_comb begin
		info.pressed = '0;
		info.clicked = '0;
		for (int k = kpar_pkg::NUM_KEYS - 1; k >= 0; k--) begin
			if (down[k]) begin
				info.pressed = kpar_pkg::KEY_W'(k + 1);
			end
			if (click[k]) begin
				info.clicked = kpar_pkg::KEY_W'(k + 1);
			end
		end
		info.down = down;
	end

endmodule

`default_nettype wire

/* design/kpar_arep.sv */
// ----------------------------------------------------------------------------
// kpar_arep: autorepeat tracker
// Holds the held key, repeat phase and last event tick; emits repeat keys.
// ----------------------------------------------------------------------------
`default_nettype none

module kpar_arep #(
	parameter int TICK_WIDTH = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           advance,
	input  wire logic                           is_scan,
	input  wire logic                           is_arep_rst,
	input  wire kpar_pkg::key_info_t            info,
	input  wire logic [TICK_WIDTH-1:0]          now,
	input  wire logic [kpar_pkg::DELAY_W-1:0]   first_delay,
	input  wire logic [kpar_pkg::DELAY_W-1:0]   repeat_delay,
	output logic      [kpar_pkg::KEY_W-1:0]     repeat_key
);

	logic [kpar_pkg::KEY_W-1:0] held_q, held_n;
	logic                       repeating_q, repeating_n;
	logic [TICK_WIDTH-1:0]      last_q, last_n;
	logic                       held_down;
	logic [TICK_WIDTH-1:0]      elapsed;
	logic [TICK_WIDTH-1:0]      delay;

	always_comb begin
		held_down = 1'b0;
		for (int k = 0; k < kpar_pkg::NUM_KEYS; k++) begin
			if (held_q == kpar_pkg::KEY_W'(k + 1)) begin
				held_down = info.down[k];
			end
		end
	end

	assign elapsed = now - last_q;
	assign delay   = TICK_WIDTH'(repeating_q ? repeat_delay : first_delay);

	always_comb begin
		held_n      = held_q;
		repeating_n = repeating_q;
		last_n      = last_q;
		repeat_key  = '0;
		if (is_scan) begin
			if (info.clicked != '0) begin
				held_n      = info.clicked;
				repeating_n = 1'b0;
				last_n      = now;
				repeat_key  = info.clicked;
			end else if (held_down) begin
				if (elapsed > delay) begin
					repeating_n = 1'b1;
					last_n      = now;
					repeat_key  = held_q;
				end
			end else begin
				held_n = '0;
			end
		end else if (is_arep_rst) begin
			held_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			repeating_q <= 1'b0;
			last_q      <= '0;
		end else if (advance) begin
			held_q      <= held_n;
			repeating_q <= repeating_n;
			last_q      <= last_n;
		end
	end

endmodule

`default_nettype wire

/* design/keypad_override_autorepeat.sv */
// ----------------------------------------------------------------------------
// keypad_override_autorepeat: keypad scanner with key injection and autorepeat
// Scans two key groups, merges injected keys, reports pressed/clicked/repeat.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream: tuser carries the operation (scan,
//   inject press, inject release, release all injected, reset autorepeat),
//   tdata the raw words, override flag, tick and key index. Every request
//   yields exactly one result on the m_ stream.
//   An accepted request passes through one input register, then the key
//   table search and state update feed the result register.
//   Throughput is one request per cycle; the input register advances
//   whenever the result register is empty or being taken.
//   When m_tready drops, the result register holds, the input register
//   fills, and s_tready then drops until the result is taken.
//   The cfg channel is always ready; write the two delay registers only
//   while no request is in flight.
//   Reset clears both stages, sets all key words to released, clears the
//   held key and loads the delays with 500 and 175 ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_override_autorepeat #(
	parameter int TICK_WIDTH = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// request stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [31:0] raw_group0, [63:32] raw_group1, [64] override_active,
	// [96:65] now_tick, [100:97] key_index, [103:101] zero
	input  wire logic [103:0] s_tdata,
	// [2:0] operation
	input  wire logic [2:0]   s_tuser,
	// result stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [31:0] status_group0, [63:32] status_group1, [67:64] pressed_key,
	// [71:68] clicked_key, [75:72] repeat_key, [79:76] zero
	output logic [79:0]       m_tdata,
	// configuration writes
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [15:0]  cfg_data
);

	localparam int NOW_W = (TICK_WIDTH < 32) ? TICK_WIDTH : 32;

	// input stage
	logic         valid_s1;
	logic [103:0] data_s1;
	logic [2:0]   op_s1;
	logic         advance;

	// result stage
	logic        valid_q;
	logic [79:0] result_q;

	// state
	logic [31:0] cur0_q, cur1_q, inj0_q, inj1_q;
	logic [15:0] first_delay_q, repeat_delay_q;

	// next-state and result logic
	logic                    is_scan, is_press, is_release, key_ok;
	logic [31:0]             raw0, raw1, cur0_n, cur1_n, inj0_n, inj1_n;
	logic [31:0]             stat0, stat1;
	logic                    ovr;
	logic [31:0]             now_raw;
	logic [TICK_WIDTH-1:0]   now_t;
	logic [3:0]              key;
	logic [15:0]             key_bits;
	logic                    key_grp;
	logic [3:0]              repeat_key;
	kpar_pkg::key_info_t     info;

	assign advance   = valid_s1 && (!valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign m_tvalid  = valid_q;
	assign m_tdata   = result_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			op_s1   <= s_tuser;
		end
	end

	assign raw0    = data_s1[31:0];
	assign raw1    = data_s1[63:32];
	assign ovr     = data_s1[64];
	assign now_raw = data_s1[96:65];
	assign key     = data_s1[100:97];
	assign now_t   = TICK_WIDTH'(now_raw[NOW_W-1:0]);

	assign is_scan    = op_s1 == kpar_pkg::OP_SCAN;
	assign is_press   = op_s1 == kpar_pkg::OP_PRESS;
	assign is_release = op_s1 == kpar_pkg::OP_RELEASE;
	assign key_ok     = (key != 4'd0) && (key <= 4'(kpar_pkg::NUM_KEYS));

	always_comb begin
		key_bits = '0;
		key_grp  = 1'b0;
		for (int k = 0; k < kpar_pkg::NUM_KEYS; k++) begin
			if (key == 4'(k + 1)) begin
				key_bits = kpar_pkg::KEY_BITS[k];
				key_grp  = kpar_pkg::KEY_GRP[k];
			end
		end
	end

	assign cur0_n = is_scan ? raw0 : cur0_q;
	assign cur1_n = is_scan ? raw1 : cur1_q;

	always_comb begin
		inj0_n = inj0_q;
		inj1_n = inj1_q;
		if ((is_press || is_release) && key_ok) begin
			if (key_grp) begin
				inj1_n = is_press ? (inj1_q & ~{16'h0, key_bits}) : (inj1_q | {16'h0, key_bits});
			end else begin
				inj0_n = is_press ? (inj0_q & ~{16'h0, key_bits}) : (inj0_q | {16'h0, key_bits});
			end
		end else if (op_s1 == kpar_pkg::OP_REL_ALL) begin
			inj0_n = inj0_q | kpar_pkg::GROUP0_MASK;
			inj1_n = inj1_q | kpar_pkg::GROUP1_MASK;
		end
	end

	// merge injected bits under the key masks
	assign stat0 = ovr ? ((cur0_n & ~kpar_pkg::GROUP0_MASK) | (inj0_n & kpar_pkg::GROUP0_MASK))
	                   : cur0_n;
	assign stat1 = ovr ? ((cur1_n & ~kpar_pkg::GROUP1_MASK) | (inj1_n & kpar_pkg::GROUP1_MASK))
	                   : cur1_n;

	// on a scan the words held so far become the previous words
	kpar_keyenc u_keyenc (
		.cur0  (cur0_n),
		.cur1  (cur1_n),
		.prev0 (cur0_q),
		.prev1 (cur1_q),
		.info  (info)
	);

	kpar_arep #(
		.TICK_WIDTH (TICK_WIDTH)
	) u_arep (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.is_scan      (is_scan),
		.is_arep_rst  (op_s1 == kpar_pkg::OP_AREP_RST),
		.info         (info),
		.now          (now_t),
		.first_delay  (first_delay_q),
		.repeat_delay (repeat_delay_q),
		.repeat_key   (repeat_key)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur0_q  <= kpar_pkg::ALL_ONES;
			cur1_q  <= kpar_pkg::ALL_ONES;
			inj0_q  <= kpar_pkg::ALL_ONES;
			inj1_q  <= kpar_pkg::ALL_ONES;
		end else if (advance) begin
			cur0_q <= cur0_n;
			cur1_q <= cur1_n;
			inj0_q <= inj0_n;
			inj1_q <= inj1_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_delay_q  <= kpar_pkg::FIRST_DELAY_RESET;
			repeat_delay_q <= kpar_pkg::REPEAT_DELAY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == kpar_pkg::CFG_FIRST_DELAY) begin
				first_delay_q <= cfg_data;
			end else if (cfg_index == kpar_pkg::CFG_REPEAT_DELAY) begin
				repeat_delay_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= {4'h0, repeat_key, (is_scan ? info.clicked : 4'h0), info.pressed,
			             stat1, stat0};
		end
	end

endmodule

`default_nettype wire

/* test/keypad_autorepeat_checker.sv */
// ----------------------------------------------------------------------------
// keypad_autorepeat_checker: result predictor and comparator for the keypad block
// Watches the request, result and register channels, keeps its own copy of the
// key words, injected mask and autorepeat state, and checks every result.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_autorepeat_checker
	import kpar_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [103:0] s_tdata,
	input  wire logic [2:0]   s_tuser,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [79:0]  m_tdata,
	input  wire logic         cfg_valid,
	input  wire logic         cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [15:0]  cfg_data,
	output int                fail_count,
	output int                reports_pending
);

	typedef struct {
		logic [WORD_W-1:0] status0;
		logic [WORD_W-1:0] status1;
		logic [KEY_W-1:0]  pressed;
		logic [KEY_W-1:0]  clicked;
		logic [KEY_W-1:0]  repeat_key;
	} keypad_report_t;

	keypad_report_t expected_reports[$];

	logic [DELAY_W-1:0] first_delay, repeat_delay;
	logic [WORD_W-1:0]  cur0, cur1, prev0, prev1, inj0, inj1;
	logic [KEY_W-1:0]   held;
	logic               repeating;
	logic [31:0]        last_tick;

	function automatic logic [15:0] key_bits_of(int unsigned key);
		case (key)
			1:  return 16'h4000;
			2:  return 16'h0400;
			3:  return 16'h0100;
			4:  return 16'h0200;
			5:  return 16'h8000;
			6:  return 16'h0300;
			7:  return 16'h0200;
			8:  return 16'h0100;
			9:  return 16'h0010;
			10: return 16'h0020;
			11: return 16'h2000;
			12: return 16'h1000;
			13: return 16'h0800;
			default: return 16'h0000;
		endcase
	endfunction

	// shoot keys live in group 0, everything else in group 1
	function automatic bit key_in_group1(int unsigned key);
		case (key)
			6, 7, 8: return 1'b0;
			default: return 1'b1;
		endcase
	endfunction

	function automatic bit key_is_low(int unsigned key);
		logic [WORD_W-1:0] word;
		if (key < 1 || key > NUM_KEYS)
			return 1'b0;
		word = key_in_group1(key) ? cur1 : cur0;
		return (word[15:0] & key_bits_of(key)) == 16'h0;
	endfunction

	function automatic logic [KEY_W-1:0] first_pressed();
		for (int k = 1; k <= NUM_KEYS; k++)
			if (key_is_low(k))
				return k[KEY_W-1:0];
		return '0;
	endfunction

	function automatic logic [KEY_W-1:0] first_clicked();
		logic [WORD_W-1:0] word;
		for (int k = 1; k <= NUM_KEYS; k++) begin
			word = key_in_group1(k) ? prev1 : prev0;
			if ((word[15:0] & key_bits_of(k)) != 16'h0 && key_is_low(k))
				return k[KEY_W-1:0];
		end
		return '0;
	endfunction

	function automatic void apply_request(input logic [OP_W-1:0] op,
			input logic [WORD_W-1:0] raw0, input logic [WORD_W-1:0] raw1,
			input logic ovr, input logic [31:0] now, input logic [KEY_W-1:0] key,
			output keypad_report_t report);
		logic [31:0]       elapsed;
		logic [WORD_W-1:0] bits;
		report.clicked = '0;
		report.repeat_key = '0;
		case (op)
			OP_SCAN: begin
				prev0 = cur0;
				prev1 = cur1;
				cur0 = raw0;
				cur1 = raw1;
				report.clicked = first_clicked();
				if (report.clicked != 0) begin
					held = report.clicked;
					repeating = 1'b0;
					last_tick = now;
					report.repeat_key = report.clicked;
				end else if (held != 0 && key_is_low(held)) begin
					elapsed = now - last_tick;
					if (elapsed > (repeating ? repeat_delay : first_delay)) begin
						repeating = 1'b1;
						last_tick = now;
						report.repeat_key = held;
					end
				end else begin
					held = '0;
				end
			end
			OP_PRESS, OP_RELEASE: begin
				if (key >= 1 && key <= NUM_KEYS) begin
					bits = {16'h0, key_bits_of(key)};
					if (key_in_group1(key))
						inj1 = (op == OP_PRESS) ? (inj1 & ~bits) : (inj1 | bits);
					else
						inj0 = (op == OP_PRESS) ? (inj0 & ~bits) : (inj0 | bits);
				end
			end
			OP_REL_ALL: begin
				inj0 |= GROUP0_MASK;
				inj1 |= GROUP1_MASK;
			end
			OP_AREP_RST: held = '0;
			default: ;
		endcase
		report.status0 = cur0;
		report.status1 = cur1;
		if (ovr) begin
			report.status0 = (cur0 & ~GROUP0_MASK) | (inj0 & GROUP0_MASK);
			report.status1 = (cur1 & ~GROUP1_MASK) | (inj1 & GROUP1_MASK);
		end
		report.pressed = first_pressed();
	endfunction

	function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch_channels
		keypad_report_t got, want;
		if (!arst_n) begin
			first_delay = FIRST_DELAY_RESET;
			repeat_delay = REPEAT_DELAY_RESET;
			{cur0, cur1, prev0, prev1} = {4{ALL_ONES}};
			{inj0, inj1} = {2{ALL_ONES}};
			held = '0;
			repeating = 1'b0;
			last_tick = '0;
			expected_reports.delete();
			reports_pending <= 0;
		end else begin
			// compare before queuing: a result never belongs to a request of the same edge
			if (m_tvalid && m_tready) begin
				got.status0 = m_tdata[31:0];
				got.status1 = m_tdata[63:32];
				got.pressed = m_tdata[67:64];
				got.clicked = m_tdata[71:68];
				got.repeat_key = m_tdata[75:72];
				if (expected_reports.size() == 0) begin
					$error("result 0x%0h arrived with no request outstanding", m_tdata);
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					check_field("status_group0", want.status0, got.status0);
					check_field("status_group1", want.status1, got.status1);
					check_field("pressed_key", want.pressed, got.pressed);
					check_field("clicked_key", want.clicked, got.clicked);
					check_field("repeat_key", want.repeat_key, got.repeat_key);
				end
			end
			if (s_tvalid && s_tready) begin
				apply_request(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[64],
					s_tdata[96:65], s_tdata[100:97], want);
				expected_reports.push_back(want);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FIRST_DELAY:  first_delay = cfg_data;
					CFG_REPEAT_DELAY: repeat_delay = cfg_data;
					default: ;
				endcase
			end
			reports_pending <= expected_reports.size();
		end
	end

endmodule

`default_nettype wire

/* test/tb_keypad_override_autorepeat.sv */
// ----------------------------------------------------------------------------
// tb_keypad_override_autorepeat: regression for the keypad override/autorepeat block
// Directed key, injection and wrap cases, then held-key sessions with random
// content under six delay settings and three idling patterns on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_keypad_override_autorepeat;
	import kpar_pkg::*;

	localparam int LIMIT_CYCLES  = 400000;
	localparam int RANDOM_ITEMS  = 930;
	localparam int SEGMENTS      = 6;
	localparam int HOLD_CYCLES   = 60;

	localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_AREP_RST + 1'b1;
	localparam logic [OP_W-1:0] OP_LAST_CODE    = {OP_W{1'b1}};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [103:0] s_tdata = '0;
	logic [2:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [79:0]  m_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = '0;
	logic [15:0]  cfg_data = '0;

	int fail_count;
	int reports_pending;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned item_count = 0;
	int unsigned hold_requests = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned cycle_count = 0;
	int unsigned cur_first = FIRST_DELAY_RESET;
	int unsigned cur_repeat = REPEAT_DELAY_RESET;
	logic [31:0] scan_tick = '0;

	int unsigned first_setting[SEGMENTS]  = '{0, 65535, 40, 500, 250, 1};
	int unsigned repeat_setting[SEGMENTS] = '{0, 65535, 15, 175, 0, 300};

	keypad_override_autorepeat dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	keypad_autorepeat_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count), .reports_pending(reports_pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("keypad_override_autorepeat regression: fail");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold whenever one is requested
	always @(posedge clk) begin
		if (hold_requests != hold_seen) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_request(input logic [2:0] op, input logic [31:0] raw0,
			input logic [31:0] raw1, input logic ovr, input logic [31:0] now,
			input logic [3:0] key);
		// idle cycle by cycle before offering
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {3'b000, key, now, ovr, raw1, raw0};
		do @(posedge clk); while (!s_tready);
		item_count++;
	endtask

	// drop the request and hold until every result is back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (reports_pending != 0);
	endtask

	task automatic set_delays(input int unsigned first, input int unsigned rep);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_FIRST_DELAY;
		cfg_data <= first[15:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_REPEAT_DELAY;
		cfg_data <= rep[15:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_first = first;
		cur_repeat = rep;
	endtask

	function automatic void add_key_press(int unsigned key, inout logic [31:0] w0,
			inout logic [31:0] w1);
		if (KEY_GRP[key-1])
			w1 &= ~{16'h0, KEY_BITS[key-1]};
		else
			w0 &= ~{16'h0, KEY_BITS[key-1]};
	endfunction

	task automatic run_directed();
		send_request(OP_SCAN, ALL_ONES, ALL_ONES, 1'b0, 32'd0, 4'd0);
		send_request(OP_SCAN, ALL_ONES, ~32'h4000, 1'b0, 32'd10, 4'd0);
		// right at the first delay, then one past it; same for the repeat delay
		send_request(OP_SCAN, ALL_ONES, ~32'h4000, 1'b0, 32'd510, 4'd0);
		send_request(OP_SCAN, ALL_ONES, ~32'h4000, 1'b0, 32'd511, 4'd0);
		send_request(OP_SCAN, ALL_ONES, ~32'h4000, 1'b0, 32'd686, 4'd0);
		send_request(OP_SCAN, ALL_ONES, ~32'h4000, 1'b0, 32'd687, 4'd0);
		send_request(OP_AREP_RST, $urandom, $urandom, 1'b0, 32'd700, 4'd0);
		send_request(OP_SCAN, ALL_ONES, ~32'h4000, 1'b0, 32'd5000, 4'd0);
		send_request(OP_SCAN, ~32'h0300, ALL_ONES, 1'b0, 32'd5001, 4'd0);
		send_request(OP_SCAN, 32'h0, 32'h0, 1'b0, 32'd5002, 4'd0);
		// click just before the tick wraps, repeat just after it
		send_request(OP_SCAN, ALL_ONES, ALL_ONES, 1'b0, 32'hFFFF_FF00, 4'd0);
		send_request(OP_SCAN, ALL_ONES, ~32'h0010, 1'b0, 32'hFFFF_FF00, 4'd0);
		send_request(OP_SCAN, ALL_ONES, ~32'h0010, 1'b0, 32'h0000_0200, 4'd0);
		send_request(OP_PRESS, $urandom, $urandom, 1'b1, 32'd0, NUM_KEYS);
		send_request(OP_PRESS, $urandom, $urandom, 1'b1, 32'd0, 4'd6);
		send_request(OP_PRESS, $urandom, $urandom, 1'b1, 32'd0, 4'd0);
		send_request(OP_PRESS, $urandom, $urandom, 1'b1, 32'd0, 4'd14);
		send_request(OP_PRESS, $urandom, $urandom, 1'b1, 32'd0, 4'd15);
		send_request(OP_RELEASE, $urandom, $urandom, 1'b1, 32'd0, NUM_KEYS);
		send_request(OP_RELEASE, $urandom, $urandom, 1'b1, 32'd0, 4'd15);
		for (int op = OP_FIRST_UNUSED; op <= OP_LAST_CODE; op++)
			send_request(op, $urandom, $urandom, 1'b1, $urandom, 4'd1);
		send_request(OP_REL_ALL, $urandom, $urandom, 1'b1, 32'd0, 4'd0);
		send_request(OP_SCAN, 32'h0, 32'h0, 1'b1, 32'hFFFF_FFFF, 4'd15);
	endtask

	task automatic run_random_segment(int unsigned count);
		int unsigned target, pick, span, hold;
		logic [31:0] w0, w1;
		target = item_count + count;
		while (item_count < target) begin
			pick = $urandom_range(99);
			span = (cur_first > cur_repeat ? cur_first : cur_repeat) / 2 + 8;
			if (pick < 70) begin
				// press one or two keys, hold them over several scans, then let go
				w0 = $urandom | GROUP0_MASK;
				w1 = $urandom | GROUP1_MASK;
				add_key_press($urandom_range(1, NUM_KEYS), w0, w1);
				if ($urandom_range(3) == 0)
					add_key_press($urandom_range(1, NUM_KEYS), w0, w1);
				hold = $urandom_range(1, 10);
				repeat (hold) begin
					scan_tick += $urandom_range(0, span);
					if ($urandom_range(9) == 0)
						send_request($urandom_range(OP_PRESS, OP_AREP_RST), $urandom,
							$urandom, $urandom_range(1), scan_tick, $urandom_range(15));
					send_request(OP_SCAN, w0, w1, $urandom_range(1), scan_tick,
						$urandom_range(15));
				end
				scan_tick += $urandom_range(0, span);
				send_request(OP_SCAN, $urandom | GROUP0_MASK, $urandom | GROUP1_MASK,
					$urandom_range(1), scan_tick, $urandom_range(15));
			end else if (pick < 90) begin
				send_request($urandom_range(OP_PRESS, OP_AREP_RST), $urandom, $urandom,
					$urandom_range(1), scan_tick, $urandom_range(15));
			end else if (pick < 96) begin
				scan_tick = $urandom;
				send_request(OP_SCAN, $urandom, $urandom, $urandom_range(1), scan_tick,
					$urandom_range(15));
			end else begin
				send_request($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE), $urandom,
					$urandom, $urandom_range(1), $urandom, $urandom_range(15));
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			drain_results();
			set_delays(first_setting[seg], repeat_setting[seg]);
			send_idle_pct = (seg < 2) ? 30 : (seg < 4) ? 81 : 0;
			recv_idle_pct = (seg < 2) ? 81 : (seg < 4) ? 30 : 0;
			// stall the result side while requests keep coming
			if (seg == 4)
				hold_requests++;
			run_random_segment(RANDOM_ITEMS / SEGMENTS);
		end
		drain_results();
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("keypad_override_autorepeat regression: pass");
		end else begin
			$display("keypad_override_autorepeat regression: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* keypad_override_autorepeat.f */
design/kpar_pkg.sv
design/kpar_keyenc.sv
design/kpar_arep.sv
design/keypad_override_autorepeat.sv
test/keypad_autorepeat_checker.sv
test/tb_keypad_override_autorepeat.sv
